@@ design/fvt_pkg.sv @@
// Shared types and constants for the frustum visibility test block.
package fvt_pkg;

    localparam int NUM_PLANES_DEF = 6;
    localparam int COORD_W        = 32;
    localparam int TOL_W          = 16;
    localparam int SLACK_W        = COORD_W + 1;
    localparam int PROD_W         = 2 * COORD_W;
    localparam int SUM_W          = PROD_W + 2;
    localparam int FRAC_BITS      = 16;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_POINT  = 2'd1,
        CMD_SPHERE = 2'd2,
        CMD_BOX    = 2'd3
    } cmd_t;

    // One transaction as it travels down the row of plane cells.
    // Tests carry the box extent in lo/hi (lo == hi for point and sphere);
    // loads carry the normal in hi and the offset in aux.
    typedef struct packed {
        logic                      valid;
        cmd_t                      cmd;
        logic [2:0]                plane_index;
        logic signed [COORD_W-1:0] lo_x;
        logic signed [COORD_W-1:0] lo_y;
        logic signed [COORD_W-1:0] lo_z;
        logic signed [COORD_W-1:0] hi_x;
        logic signed [COORD_W-1:0] hi_y;
        logic signed [COORD_W-1:0] hi_z;
        logic signed [COORD_W-1:0] aux;
        logic [SLACK_W-1:0]        slack;
        logic                      vis;
    } tok_t;

endpackage

@@ design/fvt_if.sv @@
// Handshake channels for test/load transactions and visibility results.
interface fvt_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [2:0]         plane_index;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [31:0] uz;
    logic signed [31:0] scalar;

    modport source (
        output valid, cmd, plane_index, vx, vy, vz, ux, uy, uz, scalar,
        input  ready
    );
    modport sink (
        input  valid, cmd, plane_index, vx, vy, vz, ux, uy, uz, scalar,
        output ready
    );
endinterface

interface fvt_out_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, visible, input ready);
    modport sink (input valid, visible, output ready);
endinterface

@@ design/fvt_front.sv @@
// Entry stage: sorts box corners, forms the rejection slack, registers the transaction.
module fvt_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic                            in_valid,
    input  logic [1:0]                      cmd,
    input  logic [2:0]                      plane_index,
    input  logic signed [31:0]              vx,
    input  logic signed [31:0]              vy,
    input  logic signed [31:0]              vz,
    input  logic signed [31:0]              ux,
    input  logic signed [31:0]              uy,
    input  logic signed [31:0]              uz,
    input  logic signed [31:0]              scalar,
    input  logic [fvt_pkg::TOL_W-1:0]       tolerance,
    output fvt_pkg::tok_t                   tok_out
);

    fvt_pkg::tok_t tok_reg;
    fvt_pkg::tok_t tok_next;
    fvt_pkg::cmd_t cmd_c;

    always_comb
    begin
        cmd_c                = fvt_pkg::cmd_t'(cmd);
        tok_next             = '0;
        tok_next.valid       = in_valid;
        tok_next.cmd         = cmd_c;
        tok_next.plane_index = plane_index;
        tok_next.aux         = scalar;
        tok_next.vis         = 1'b1;
        tok_next.lo_x        = vx;
        tok_next.lo_y        = vy;
        tok_next.lo_z        = vz;
        tok_next.hi_x        = vx;
        tok_next.hi_y        = vy;
        tok_next.hi_z        = vz;
        tok_next.slack       = fvt_pkg::SLACK_W'(tolerance);
        case (cmd_c)
            fvt_pkg::CMD_SPHERE:
            begin
                // negative radius: invisible outright
                if (scalar[31])
                    tok_next.vis = 1'b0;
                tok_next.slack = fvt_pkg::SLACK_W'(scalar[30:0])
                               + fvt_pkg::SLACK_W'(tolerance);
            end
            fvt_pkg::CMD_BOX:
            begin
                if (ux < vx)
                begin
                    tok_next.lo_x = ux;
                end
                else
                begin
                    tok_next.hi_x = ux;
                end
                if (uy < vy)
                begin
                    tok_next.lo_y = uy;
                end
                else
                begin
                    tok_next.hi_y = uy;
                end
                if (uz < vz)
                begin
                    tok_next.lo_z = uz;
                end
                else
                begin
                    tok_next.hi_z = uz;
                end
            end
            default:
            begin
                tok_next.slack = fvt_pkg::SLACK_W'(tolerance);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

@@ design/fvt_cell.sv @@
// One plane cell: holds a plane, multiplies in stage one, sums and compares in stage two.
module fvt_cell #(
    parameter int CELL_ID = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  fvt_pkg::tok_t tok_in,
    output fvt_pkg::tok_t tok_out
);

    logic signed [fvt_pkg::COORD_W-1:0] nx_reg, ny_reg, nz_reg, w_reg;
    logic signed [fvt_pkg::COORD_W-1:0] cx, cy, cz;
    logic signed [fvt_pkg::PROD_W-1:0]  px_reg, py_reg, pz_reg;
    logic signed [fvt_pkg::PROD_W-1:0]  px_next, py_next, pz_next;
    logic signed [fvt_pkg::COORD_W-1:0] wm_reg;
    logic signed [fvt_pkg::SUM_W-1:0]   dist_sum;
    logic                               load_hit;
    logic                               reject;
    fvt_pkg::tok_t                      mid_reg;
    fvt_pkg::tok_t                      out_reg;
    fvt_pkg::tok_t                      out_next;

    // pick the corner furthest along the normal; lo == hi except for boxes
    always_comb
    begin
        cx      = nx_reg[31] ? tok_in.lo_x : tok_in.hi_x;
        cy      = ny_reg[31] ? tok_in.lo_y : tok_in.hi_y;
        cz      = nz_reg[31] ? tok_in.lo_z : tok_in.hi_z;
        px_next = fvt_pkg::PROD_W'(nx_reg) * fvt_pkg::PROD_W'(cx);
        py_next = fvt_pkg::PROD_W'(ny_reg) * fvt_pkg::PROD_W'(cy);
        pz_next = fvt_pkg::PROD_W'(nz_reg) * fvt_pkg::PROD_W'(cz);
    end

    assign load_hit = advance && tok_in.valid && (tok_in.cmd == fvt_pkg::CMD_LOAD)
                   && (32'(tok_in.plane_index) == 32'(CELL_ID));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg <= '0;
            ny_reg <= '0;
            nz_reg <= '0;
            w_reg  <= '0;
        end
        else if (load_hit)
        begin
            nx_reg <= tok_in.hi_x;
            ny_reg <= tok_in.hi_y;
            nz_reg <= tok_in.hi_z;
            w_reg  <= tok_in.aux;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            pz_reg <= pz_next;
            wm_reg <= w_reg;
        end
    end

    // exact signed distance plus slack, both offsets scaled to Q32.32
    always_comb
    begin
        dist_sum = fvt_pkg::SUM_W'(px_reg) + fvt_pkg::SUM_W'(py_reg)
                 + fvt_pkg::SUM_W'(pz_reg)
                 + (fvt_pkg::SUM_W'(wm_reg) <<< fvt_pkg::FRAC_BITS)
                 + $signed(fvt_pkg::SUM_W'(mid_reg.slack) << fvt_pkg::FRAC_BITS);
        reject       = (mid_reg.cmd != fvt_pkg::CMD_LOAD) && dist_sum[fvt_pkg::SUM_W-1];
        out_next     = mid_reg;
        out_next.vis = mid_reg.vis && !reject;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg <= '0;
            out_reg <= '0;
        end
        else if (advance)
        begin
            mid_reg <= tok_in;
            out_reg <= out_next;
        end
    end

    assign tok_out = out_reg;

endmodule

@@ design/frustum_visibility_test.sv @@
// Top level of the frustum visibility test: entry stage, row of plane cells, result register.
//
// Every transaction (plane load or test) enters an entry stage and then walks a row of
// NUM_PLANES plane cells, two register stages per cell (multiply, then sum and compare),
// and then reaches the result register, valid only for tests. Loads travel the same
// row and update their cell when they pass it, so tests see exactly the planes loaded
// before them. The row moves one step per cycle whenever the result register is free or
// being taken, so one transaction is accepted per cycle; only a stalled result holds the
// row. Loads give no result; a load index of NUM_PLANES or above is dropped. Planes reset
// to zero and tolerance to 7; write tolerance only while no transaction is in flight.
module frustum_visibility_test #(
    parameter int NUM_PLANES = fvt_pkg::NUM_PLANES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [fvt_pkg::TOL_W-1:0] cfg_wdata,
    fvt_in_if.sink                    item,
    fvt_out_if.source                 result
);

    logic [fvt_pkg::TOL_W-1:0] tol_reg;
    logic                      advance;
    logic                      res_valid_reg;
    logic                      res_visible_reg;
    fvt_pkg::tok_t             chain [NUM_PLANES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= fvt_pkg::TOL_RESET;
        end
        else if (cfg_we)
        begin
            tol_reg <= cfg_wdata;
        end
    end

    // advance the whole row unless a result is waiting and not being taken
    assign advance    = !res_valid_reg || result.ready;
    assign item.ready = advance;

    fvt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (item.valid),
        .cmd         (item.cmd),
        .plane_index (item.plane_index),
        .vx          (item.vx),
        .vy          (item.vy),
        .vz          (item.vz),
        .ux          (item.ux),
        .uy          (item.uy),
        .uz          (item.uz),
        .scalar      (item.scalar),
        .tolerance   (tol_reg),
        .tok_out     (chain[0])
    );

    for (genvar g = 0; g < NUM_PLANES; g++)
    begin : g_cell
        fvt_cell #(
            .CELL_ID (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= chain[NUM_PLANES].valid
                          && (chain[NUM_PLANES].cmd != fvt_pkg::CMD_LOAD);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_visible_reg <= chain[NUM_PLANES].vis;
        end
    end

    assign result.valid   = res_valid_reg;
    assign result.visible = res_visible_reg;

endmodule
